// ===== rtl/calendar_date_add_core_assert.svh =====
// Assertion macros shared by the calendar date adder.
`ifndef CALENDAR_DATE_ADD_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADD_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CDA_ASSERT_IMP(lbl, ante, cons, msg)
`define CDA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cda_pkg.sv =====
`timescale 1ns / 1ps

package cda_pkg;

    localparam int QueueDepthDefault = 2;

    localparam logic [3:0] MonthsPerYear = 4'd12;
    localparam logic [3:0] MonthFeb      = 4'd1;
    localparam logic [3:0] MonthJul      = 4'd7;
    localparam logic [3:0] MonthDec      = 4'd11;
    localparam logic [4:0] LenFebLeap    = 5'd29;
    localparam logic [4:0] LenFeb        = 5'd28;
    localparam logic [4:0] LenLong       = 5'd31;
    localparam logic [4:0] LenShort      = 5'd30;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  days;
        logic [3:0]  month_add;
        logic [8:0]  year_add;
    } cda_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT1,
        ST_WAIT2,
        ST_START,
        ST_WALK,
        ST_MONTHS,
        ST_END
    } back_state_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_WALK,
        PH_END
    } phase_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MonthFeb)
        begin
            len = leap ? LenFebLeap : LenFeb;
        end
        else if (month < MonthJul)
        begin
            len = LenLong - {4'd0, month[0]};
        end
        else
        begin
            len = LenShort + {4'd0, month[0]};
        end
        return len;
    endfunction

endpackage

// ===== rtl/cda_queue.sv =====
`timescale 1ns / 1ps

module cda_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cda_pkg::cda_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output cda_pkg::cda_item_t pop_item
);
    import cda_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    cda_item_t       mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CntW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/cda_front.sv =====
`timescale 1ns / 1ps

module cda_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,
    output logic               push,
    output cda_pkg::cda_item_t push_item,
    input  logic               full
);
    import cda_pkg::*;

    logic        valid_reg, valid_next;
    cda_item_t   item_reg, item_next;
    logic        accept;
    logic [3:0]  in_month;
    logic [7:0]  in_months;
    logic [15:0] quot_prod;
    logic [4:0]  months_quot;
    logic [7:0]  months_q12;

    assign s_tready  = !valid_reg || !full;
    assign accept    = s_tvalid && s_tready;
    assign push      = valid_reg && !full;
    assign push_item = item_reg;

    // The month delta is split into whole years and a remainder by a reciprocal multiply.
    always_comb
    begin
        in_month    = s_tdata[19:16];
        in_months   = s_tdata[40:33];
        quot_prod   = 16'(in_months * 8'd171);
        months_quot = quot_prod[15:11];
        months_q12  = {months_quot, 3'b000} + {1'b0, months_quot, 2'b00};

        item_next.year      = s_tdata[15:0];
        item_next.month     = (in_month >= MonthsPerYear) ? in_month - MonthsPerYear : in_month;
        item_next.day       = s_tdata[24:20];
        item_next.days      = s_tdata[32:25];
        item_next.month_add = 4'(in_months - months_q12);
        item_next.year_add  = {1'b0, s_tdata[48:41]} + {4'd0, months_quot};

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/cda_leap.sv =====
`timescale 1ns / 1ps

module cda_leap (
    input  logic        clk,
    input  logic [15:0] year,
    output logic        leap
);
    import cda_pkg::*;

    logic [15:0] year_reg, year_next;
    logic [9:0]  cent_reg, cent_next;
    logic        leap_reg, leap_next;
    logic [30:0] cent_prod;
    logic [15:0] cent_x100;

    assign leap = leap_reg;

    // Two stages: the century count by reciprocal multiply, then the leap rule.
    always_comb
    begin
        cent_prod = 31'(year * 15'd20972);
        year_next = year;
        cent_next = cent_prod[30:21];
        cent_x100 = {cent_reg, 6'd0} + {1'b0, cent_reg, 5'd0} + {4'd0, cent_reg, 2'd0};
        leap_next = (year_reg[1:0] == 2'b00) &&
                    ((year_reg != cent_x100) || (cent_reg[1:0] == 2'b00));
    end

    always_ff @(posedge clk)
    begin
        year_reg <= year_next;
        cent_reg <= cent_next;
        leap_reg <= leap_next;
    end

endmodule

// ===== rtl/cda_back.sv =====
`timescale 1ns / 1ps

module cda_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cda_pkg::cda_item_t q_item,
    output logic               q_pop,
    output logic [15:0]        leap_year,
    input  logic               leap,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tuser
);
    import cda_pkg::*;

    back_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [16:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [7:0]  days_reg, days_next;
    logic [3:0]  month_add_reg, month_add_next;
    logic [8:0]  year_add_reg, year_add_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_year_reg, out_year_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic        out_wrap_reg, out_wrap_next;
    logic        out_load;
    logic [4:0]  len;
    logic [4:0]  left;
    logic [4:0]  day_clamped;
    logic [4:0]  month_sum;
    logic        month_carry;

    assign leap_year = year_reg[15:0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_day_reg, out_month_reg, out_year_reg};
    assign m_tuser   = out_wrap_reg;

    always_comb
    begin
        len         = month_len(month_reg, leap);
        left        = len - day_reg;
        day_clamped = (day_reg >= len) ? len - 5'd1 : day_reg;
        month_sum   = {1'b0, month_reg} + {1'b0, month_add_reg};
        month_carry = (month_sum >= {1'b0, MonthsPerYear});

        state_next     = state_reg;
        phase_next     = phase_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        days_next      = days_reg;
        month_add_next = month_add_reg;
        year_add_next  = year_add_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_wrap_next  = out_wrap_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    year_next      = {1'b0, q_item.year};
                    month_next     = q_item.month;
                    day_next       = q_item.day;
                    days_next      = q_item.days;
                    month_add_next = q_item.month_add;
                    year_add_next  = q_item.year_add;
                    phase_next     = PH_START;
                    state_next     = ST_WAIT1;
                end
            end
            ST_WAIT1:
            begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                case (phase_reg)
                    PH_START: state_next = ST_START;
                    PH_WALK:  state_next = ST_WALK;
                    default:  state_next = ST_END;
                endcase
            end
            ST_START:
            begin
                day_next   = day_clamped;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (days_reg == 8'd0)
                begin
                    state_next = ST_MONTHS;
                end
                else if (days_reg >= {3'd0, left})
                begin
                    days_next = days_reg - {3'd0, left};
                    day_next  = 5'd0;
                    if (month_reg == MonthDec)
                    begin
                        month_next = 4'd0;
                        year_next  = year_reg + 17'd1;
                        phase_next = PH_WALK;
                        state_next = ST_WAIT1;
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    day_next   = day_reg + days_reg[4:0];
                    days_next  = 8'd0;
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS:
            begin
                month_next = month_carry ? 4'(month_sum - {1'b0, MonthsPerYear})
                                         : month_sum[3:0];
                year_next  = year_reg + {16'd0, month_carry} + {8'd0, year_add_reg};
                phase_next = PH_END;
                state_next = ST_WAIT1;
            end
            ST_END:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_year_next  = year_reg[15:0];
                    out_month_next = month_reg;
                    out_day_next   = day_clamped;
                    out_wrap_next  = year_reg[16];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        days_reg      <= days_next;
        month_add_reg <= month_add_next;
        year_add_reg  <= year_add_next;
        if (out_load)
        begin
            out_year_reg  <= out_year_next;
            out_month_reg <= out_month_next;
            out_day_reg   <= out_day_next;
            out_wrap_reg  <= out_wrap_next;
        end
    end

endmodule

// ===== rtl/calendar_date_add_core.sv =====
`timescale 1ns / 1ps
`include "calendar_date_add_core_assert.svh"

// Channel | Direction | Signals                         | Beat
// s       | in        | s_tvalid s_tready s_tdata[55:0] | one start date and delta
// m       | out       | m_tvalid m_tready m_tdata m_tuser | one result date
//
// The day walk moves one month per cycle, and each year change waits in ST_WAIT1
// and ST_WAIT2 for the pipelined leap-year unit. A front register and a short
// queue take new beats while the back end works. Reset clears all handshake and
// sequencer state. A stalled output keeps its result while the next item is
// already accepted.

module calendar_date_add_core #(
    parameter int QUEUE_DEPTH = cda_pkg::QueueDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: start_year[16], start_month[4], start_day[5],
    // add_days[8], add_months[8], add_years[8], zero fill[7].
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: result_year[16], result_month[4], result_day[5],
    // zero fill[7].
    output logic [31:0] m_tdata,
    // m_tuser: year_wrapped[1].
    output logic        m_tuser
);
    import cda_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    cda_item_t   q_in_item;
    cda_item_t   q_out_item;
    logic [15:0] leap_year;
    logic        leap;

    cda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full)
    );

    cda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out_item)
    );

    cda_leap u_leap (
        .clk  (clk),
        .year (leap_year),
        .leap (leap)
    );

    cda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .leap_year (leap_year),
        .leap      (leap),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `CDA_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
    `CDA_ASSERT_IMP(a_push_room, q_push, !q_full, "queue pushed while full")
    `CDA_ASSERT_NXT(a_pop_spacing, q_pop, !q_pop, "back end took two items in a row")
    `CDA_ASSERT_IMP(a_wrap_small, m_tvalid && m_tuser, m_tdata[15:0] < 16'd300, "wrapped year too large")

endmodule
